// ===== rtl/bdpc_pkg.sv =====
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int unsigned DebWidth  = 8;
    localparam int unsigned HeldWidth = 16;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned InTdataWidth  = 8;
    localparam int unsigned OutTdataWidth = 8;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_DEBOUNCE_TICKS  = 2'd0,
        REG_SHORT_PRESS_MAX = 2'd1,
        REG_LONG_PRESS_MIN  = 2'd2,
        REG_LONG_PRESS_MAX  = 2'd3
    } cfg_index_t;

    localparam logic [DebWidth-1:0]  DebounceTicksReset = 8'd15;
    localparam logic [HeldWidth-1:0] ShortPressMaxReset = 16'd1000;
    localparam logic [HeldWidth-1:0] LongPressMinReset  = 16'd2000;
    localparam logic [HeldWidth-1:0] LongPressMaxReset  = 16'd4000;

    localparam logic [DebWidth-1:0]  DebSat  = '1;
    localparam logic [HeldWidth-1:0] HeldSat = '1;

    localparam logic LevelReleased = 1'b1;
    localparam logic LevelPressed  = 1'b0;

    typedef struct packed {
        logic hold_timeout_event;
        logic long_press_event;
        logic release_event;
        logic short_press_event;
        logic press_event;
        logic debounced_level;
    } result_t;

endpackage

// ===== rtl/button_debounce_press_classifier_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata[0] pin_level
// m_       out        m_tvalid / m_tready  m_tdata[5:0] result flags
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per clock is accepted unless stalled; its result is ready the next cycle.
// The state update runs in the cycle of acceptance, so there is no loop
// across words beyond a single compare-and-count step.
// The input stalls only while a result is held and m_tready is low.
// Reset (aresetn, synchronous) restores the default limits and the released state.

module button_debounce_press_classifier_unit
    import bdpc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [InTdataWidth-1:0]   s_tdata,   // [0] pin_level, [7:1] zero
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] debounced_level, [1] press_event, [2] short_press_event,
    // [3] release_event, [4] long_press_event, [5] hold_timeout_event, [7:6] zero
    output logic [OutTdataWidth-1:0]  m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CfgIdxWidth-1:0]    cfg_index,
    input  logic [CfgDataWidth-1:0]   cfg_data
);

    logic [DebWidth-1:0]  debounce_ticks_reg;
    logic [HeldWidth-1:0] short_press_max_reg;
    logic [HeldWidth-1:0] long_press_min_reg;
    logic [HeldWidth-1:0] long_press_max_reg;

    logic                 raw_seen_reg, raw_seen_next;
    logic                 debounce_active_reg, debounce_active_next;
    logic [DebWidth-1:0]  stable_count_reg, stable_count_next;
    logic                 accepted_level_reg, accepted_level_next;
    logic [HeldWidth-1:0] held_count_reg, held_count_next;
    logic                 long_pending_reg, long_pending_next;
    logic                 timeout_pending_reg, timeout_pending_next;

    logic                 m_tvalid_reg;
    result_t              result_reg, result_next;

    logic                 pin;
    logic                 s_accept;
    logic                 level_edge;
    logic [HeldWidth-1:0] held_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OutTdataWidth - $bits(result_t)){1'b0}}, result_reg};
    assign pin       = s_tdata[0];

    always_comb begin
        raw_seen_next        = raw_seen_reg;
        debounce_active_next = debounce_active_reg;
        stable_count_next    = stable_count_reg;
        accepted_level_next  = accepted_level_reg;
        long_pending_next    = long_pending_reg;
        timeout_pending_next = timeout_pending_reg;
        result_next          = '0;

        held_inc = (held_count_reg == HeldSat) ? held_count_reg
                                               : held_count_reg + 1'b1;

        if (pin != raw_seen_reg) begin
            raw_seen_next        = pin;
            debounce_active_next = 1'b1;
            stable_count_next    = '0;
        end else if (debounce_active_reg && stable_count_reg != DebSat) begin
            stable_count_next = stable_count_reg + 1'b1;
        end

        if (debounce_active_next && stable_count_next >= debounce_ticks_reg) begin
            accepted_level_next  = raw_seen_next;
            debounce_active_next = 1'b0;
        end

        level_edge      = accepted_level_next != accepted_level_reg;
        held_count_next = held_inc;

        if (level_edge && accepted_level_next == LevelPressed) begin
            long_pending_next       = 1'b1;
            timeout_pending_next    = 1'b1;
            result_next.press_event = 1'b1;
            held_count_next         = '0;
        end
        if (level_edge && accepted_level_next == LevelReleased) begin
            result_next.short_press_event = held_inc <= short_press_max_reg;
            result_next.release_event     = 1'b1;
            long_pending_next             = 1'b0;
            timeout_pending_next          = 1'b0;
        end

        if (long_pending_next && held_count_next >= long_press_min_reg
                && held_count_next <= long_press_max_reg) begin
            result_next.long_press_event = 1'b1;
            long_pending_next            = 1'b0;
        end
        if (timeout_pending_next && held_count_next > long_press_max_reg) begin
            result_next.hold_timeout_event = 1'b1;
            long_pending_next              = 1'b0;
            timeout_pending_next           = 1'b0;
        end

        result_next.debounced_level = accepted_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg  <= DebounceTicksReset;
            short_press_max_reg <= ShortPressMaxReset;
            long_press_min_reg  <= LongPressMinReset;
            long_press_max_reg  <= LongPressMaxReset;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                REG_DEBOUNCE_TICKS:  debounce_ticks_reg  <= cfg_data[DebWidth-1:0];
                REG_SHORT_PRESS_MAX: short_press_max_reg <= cfg_data;
                REG_LONG_PRESS_MIN:  long_press_min_reg  <= cfg_data;
                REG_LONG_PRESS_MAX:  long_press_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_seen_reg        <= LevelReleased;
            debounce_active_reg <= 1'b0;
            stable_count_reg    <= '0;
            accepted_level_reg  <= LevelReleased;
            held_count_reg      <= '0;
            long_pending_reg    <= 1'b0;
            timeout_pending_reg <= 1'b0;
            m_tvalid_reg        <= 1'b0;
        end else begin
            if (s_accept) begin
                raw_seen_reg        <= raw_seen_next;
                debounce_active_reg <= debounce_active_next;
                stable_count_reg    <= stable_count_next;
                accepted_level_reg  <= accepted_level_next;
                held_count_reg      <= held_count_next;
                long_pending_reg    <= long_pending_next;
                timeout_pending_reg <= timeout_pending_next;
                m_tvalid_reg        <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

endmodule
